>>> sv/rae_pkg.sv
// Shared types, constants and functions of the radix alphabet encoder.
package rae_pkg;

   // Width of the input field and of the part of it that is encoded
   localparam int NUMBER_W   = 63;
   localparam int VALUE_BITS = 63;

   // Digit and character widths (radix is at most 62)
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   // Divider step counter
   localparam int STEP_W = $clog2(VALUE_BITS);

   // Front queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Symbol group sizes
   localparam logic [DIGIT_W-1:0] LOWER_COUNT = DIGIT_W'(26);
   localparam logic [DIGIT_W-1:0] UPPER_COUNT = DIGIT_W'(26);
   localparam logic [DIGIT_W-1:0] DIGIT_COUNT = DIGIT_W'(10);

   // ASCII codes of the first symbol of each group
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_USE_LOWER    = 2'd0;
   localparam logic [1:0] REG_USE_UPPER    = 2'd1;
   localparam logic [1:0] REG_USE_NUMERALS = 2'd2;

   typedef struct packed {
      logic use_lower;
      logic use_upper;
      logic use_numerals;
   } cfg_type;

   // Head of the front queue as seen by the back end
   typedef struct packed {
      logic                  valid;
      logic                  is_zero;
      logic [VALUE_BITS-1:0] value;
   } q_head_type;

   typedef struct packed {
      logic                  is_zero;
      logic [VALUE_BITS-1:0] value;
   } q_entry_type;

   // Divider command and result
   typedef struct packed {
      logic                  start;
      logic [VALUE_BITS-1:0] dividend;
      logic [DIGIT_W-1:0]    divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [VALUE_BITS-1:0] quot;
      logic [DIGIT_W-1:0]    rem;
   } div_res_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   // Radix from the enabled groups; digits only when none is enabled
   function automatic logic [DIGIT_W-1:0] alpha_size(input cfg_type cfg);
      logic [DIGIT_W-1:0] s;
      s = '0;
      if (cfg.use_lower)    s = s + LOWER_COUNT;
      if (cfg.use_upper)    s = s + UPPER_COUNT;
      if (cfg.use_numerals) s = s + DIGIT_COUNT;
      if (s == '0)          s = DIGIT_COUNT;
      return s;
   endfunction

   // Map a digit value through the enabled groups: lower, upper, digits
   function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d,
                                                   input cfg_type cfg);
      logic [DIGIT_W-1:0] rest;
      logic [CHAR_W-1:0]  code;
      logic               found;
      rest  = d;
      code  = CHAR_ZERO;
      found = 1'b0;
      if (cfg.use_lower) begin
         if (rest < LOWER_COUNT) begin
            code  = CHAR_LOWER_A + CHAR_W'(rest);
            found = 1'b1;
         end else begin
            rest = rest - LOWER_COUNT;
         end
      end
      if (!found && cfg.use_upper) begin
         if (rest < UPPER_COUNT) begin
            code  = CHAR_UPPER_A + CHAR_W'(rest);
            found = 1'b1;
         end else begin
            rest = rest - UPPER_COUNT;
         end
      end
      if (!found) begin
         code = CHAR_ZERO + CHAR_W'(rest);
      end
      return code;
   endfunction

endpackage

>>> sv/rae_req_if.sv
// Input channel: one number per transaction.
interface rae_req_if;
   logic                          valid;
   logic                          ready;
   logic [rae_pkg::NUMBER_W-1:0]  number_in;

   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

>>> sv/rae_rsp_if.sv
// Result channel: one symbol per transaction.
interface rae_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rae_pkg::CHAR_W-1:0]  char_code;
   logic                        last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> sv/rae_front.sv
// Front end: accepts numbers, flags zero values and queues them for the back end.
module rae_front (
   input  logic                 clock,
   input  logic                 reset,
   rae_req_if.sink              req_bus,
   input  logic                 pop,
   output rae_pkg::q_head_type  head
);

   rae_pkg::q_entry_type            mem_ff [rae_pkg::QUEUE_DEPTH];
   logic [rae_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rae_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rae_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            push;
   logic                            do_pop;
   rae_pkg::q_entry_type            entry;

   // Accept while the queue has room
   assign req_bus.ready = (count_ff != rae_pkg::QCNT_W'(rae_pkg::QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign do_pop        = pop && (count_ff != '0);

   // Classify: keep the encoded bits and mark a zero value
   always_comb begin
      entry.value   = req_bus.number_in[rae_pkg::VALUE_BITS-1:0];
      entry.is_zero = (req_bus.number_in[rae_pkg::VALUE_BITS-1:0] == '0);
   end

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rae_pkg::QPTR_W'(rae_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == rae_pkg::QPTR_W'(rae_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   // Present the oldest entry
   always_comb begin
      head.valid   = (count_ff != '0);
      head.is_zero = mem_ff[rd_ptr_ff].is_zero;
      head.value   = mem_ff[rd_ptr_ff].value;
   end

endmodule

>>> sv/rae_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module rae_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rae_pkg::div_cmd_type  cmd,
   output rae_pkg::div_res_type  res
);

   logic [rae_pkg::VALUE_BITS-1:0] quot_ff, quot_in;
   logic [rae_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [rae_pkg::DIGIT_W-1:0]    divisor_ff, divisor_in;
   logic [rae_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [rae_pkg::DIGIT_W:0]      trial;
   logic                           fits;

   // Shift the next dividend bit into the partial remainder and compare
   assign trial = {rem_ff, quot_ff[rae_pkg::VALUE_BITS-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         quot_in    = cmd.dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
         cnt_in     = rae_pkg::STEP_W'(rae_pkg::VALUE_BITS - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[rae_pkg::VALUE_BITS-2:0], fits};
         rem_in  = fits ? rae_pkg::DIGIT_W'(trial - {1'b0, divisor_ff}) :
                          trial[rae_pkg::DIGIT_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   always_comb begin
      res.busy = busy_ff;
      res.done = done_ff;
      res.quot = quot_ff;
      res.rem  = rem_ff;
   end

endmodule

>>> sv/rae_back.sv
// Back end: sequences digit divisions, maps digits to symbols, holds the result register.
module rae_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rae_pkg::cfg_type      cfg,
   input  rae_pkg::q_head_type   head,
   output logic                  pop,
   output rae_pkg::div_cmd_type  div_cmd,
   input  rae_pkg::div_res_type  div_res,
   rae_rsp_if.source             rsp_bus
);

   rae_pkg::back_state_type         state_ff, state_in;
   logic [rae_pkg::DIGIT_W-1:0]     digit_ff, digit_in;
   logic [rae_pkg::VALUE_BITS-1:0]  val_ff, val_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rae_pkg::CHAR_W-1:0]      char_ff, char_in;
   logic                            last_ff, last_in;
   logic                            slot_free;
   logic                            load_out;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state and divider commands
   always_comb begin
      state_in         = state_ff;
      digit_in         = digit_ff;
      val_in           = val_ff;
      pop              = 1'b0;
      load_out         = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = val_ff;
      div_cmd.divisor  = rae_pkg::alpha_size(cfg);
      case (state_ff)
         rae_pkg::BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.is_zero) begin
                  digit_in = '0;
                  val_in   = '0;
                  state_in = rae_pkg::BK_EMIT;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = head.value;
                  state_in         = rae_pkg::BK_DIV;
               end
            end
         end
         rae_pkg::BK_DIV: begin
            if (div_res.done) begin
               digit_in = div_res.rem;
               val_in   = div_res.quot;
               state_in = rae_pkg::BK_EMIT;
            end
         end
         rae_pkg::BK_EMIT: begin
            if (slot_free) begin
               load_out = 1'b1;
               if (val_ff == '0) begin
                  state_in = rae_pkg::BK_IDLE;
               end else begin
                  div_cmd.start = 1'b1;
                  state_in      = rae_pkg::BK_DIV;
               end
            end
         end
         default: begin
            state_in = rae_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rae_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
      val_ff   <= val_in;
   end

   // Load the result register; drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         char_in      = rae_pkg::symbol_of(digit_ff, cfg);
         last_in      = (val_ff == '0);
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = char_ff;
   assign rsp_bus.last_char = last_ff;

endmodule

>>> sv/radix_alphabet_encoder_top.sv
// Radix alphabet encoder: writes a number in radix S as ASCII symbols.
//
// Usage:
//   req_bus carries one 63-bit number per transaction (valid/ready).
//   rsp_bus returns its digits in radix S, least significant first, one
//   ASCII symbol per transaction; last_char marks the most significant one.
//   A zero input gives a single symbol, the first of the alphabet.
//   The APB port at csr_ holds three enables (0x0 lower, 0x4 upper,
//   0x8 numerals); S is the sum of the enabled group sizes, 10 if none.
//   Write the enables only while the block is idle.
// Flow:
//   Digits come one at a time from the bit-serial divider, least
//   significant first; once the last symbol of a number is loaded into
//   the result register, the next queued number starts.
//   A two-entry queue accepts new numbers while the current one is worked.
// Reset: synchronous; all enables return to 1, queue and result empty.
// Stall: while rsp_bus.ready is low the result register holds and the
//   back end waits; the queue keeps accepting until full.
module radix_alphabet_encoder_top (
   input  logic                              clock,
   input  logic                              reset,
   rae_req_if.sink                           req_bus,
   rae_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rae_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rae_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rae_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   rae_pkg::cfg_type      cfg_ff, cfg_in;
   rae_pkg::q_head_type   head;
   rae_pkg::div_cmd_type  div_cmd;
   rae_pkg::div_res_type  div_res;
   logic                  pop;
   logic                  csr_wr;
   logic [1:0]            reg_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // Register writes keep bit 0; other indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            rae_pkg::REG_USE_LOWER:    cfg_in.use_lower    = csr_pwdata[0];
            rae_pkg::REG_USE_UPPER:    cfg_in.use_upper    = csr_pwdata[0];
            rae_pkg::REG_USE_NUMERALS: cfg_in.use_numerals = csr_pwdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{use_lower: 1'b1, use_upper: 1'b1, use_numerals: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         rae_pkg::REG_USE_LOWER:    csr_prdata[0] = cfg_ff.use_lower;
         rae_pkg::REG_USE_UPPER:    csr_prdata[0] = cfg_ff.use_upper;
         rae_pkg::REG_USE_NUMERALS: csr_prdata[0] = cfg_ff.use_numerals;
         default:                   csr_prdata    = '0;
      endcase
   end

   rae_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .pop     (pop),
      .head    (head)
   );

   rae_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   rae_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .pop     (pop),
      .div_cmd (div_cmd),
      .div_res (div_res),
      .rsp_bus (rsp_bus)
   );

   // An accepted number is in the queue at the next edge
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> head.valid)
      else $error("accepted transaction missing from queue");

   // A division completes only after a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> $past(div_res.busy))
      else $error("divider done without a busy cycle");

   // Symbols come from the alphabet only
   a_symbol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         ((rsp_bus.char_code >= 7'd48) && (rsp_bus.char_code <= 7'd57)) ||
         ((rsp_bus.char_code >= 7'd65) && (rsp_bus.char_code <= 7'd90)) ||
         ((rsp_bus.char_code >= 7'd97) && (rsp_bus.char_code <= 7'd122)))
      else $error("symbol outside the alphabet");

endmodule

>>> dv/rae_symbol_checker.sv
// Checker for the radix alphabet encoder: tracks the alphabet, predicts symbols, compares.
`timescale 1ns / 1ps

module rae_symbol_checker
   import rae_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rae_req_if                    req_mon,
   rae_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    symbol_errors,
   output int                    symbols_pending
);

   // A 63-bit value in radix 10 has at most 19 digits
   localparam int MAX_SYMBOLS = 19;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } symbol_type;

   cfg_type         alphabet;
   symbol_type      expected_symbols[$];
   int              error_tally;
   symbol_type      predicted;
   symbol_type      observed;
   logic [1:0]      reg_index;

   // Radix of the current alphabet; an empty alphabet falls back to digits
   function automatic logic [DIGIT_W-1:0] current_radix();
      logic [DIGIT_W-1:0] total;
      total = (alphabet.use_lower    ? LOWER_COUNT : DIGIT_W'(0))
            + (alphabet.use_upper    ? UPPER_COUNT : DIGIT_W'(0))
            + (alphabet.use_numerals ? DIGIT_COUNT : DIGIT_W'(0));
      return (total == DIGIT_W'(0)) ? DIGIT_COUNT : total;
   endfunction

   // Walk the enabled groups in order lower, upper, digits
   function automatic logic [CHAR_W-1:0] symbol_code(input logic [DIGIT_W-1:0] digit);
      logic [DIGIT_W-1:0] rest;
      rest = digit;
      if (alphabet.use_lower) begin
         if (rest < LOWER_COUNT) return CHAR_LOWER_A + CHAR_W'(rest);
         rest = rest - LOWER_COUNT;
      end
      if (alphabet.use_upper) begin
         if (rest < UPPER_COUNT) return CHAR_UPPER_A + CHAR_W'(rest);
         rest = rest - UPPER_COUNT;
      end
      return CHAR_ZERO + CHAR_W'(rest);
   endfunction

   // Queue the symbols of one number, least significant digit first
   function automatic void predict_symbols(input logic [NUMBER_W-1:0] number);
      longint unsigned    rest;
      logic [DIGIT_W-1:0] radix;
      logic [DIGIT_W-1:0] digit;
      symbol_type         sym;
      int                 count;
      rest  = 64'(number[VALUE_BITS-1:0]);
      radix = current_radix();
      count = 0;
      do begin
         digit            = DIGIT_W'(rest % 64'(radix));
         rest             = rest / 64'(radix);
         sym.char_code    = symbol_code(digit);
         sym.last_char    = (rest == 0);
         expected_symbols = {expected_symbols, sym};
         count++;
      end while (rest != 0 && count < MAX_SYMBOLS);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         alphabet         = '{use_lower: 1'b1, use_upper: 1'b1, use_numerals: 1'b1};
         expected_symbols.delete();
         error_tally      = 0;
      end else begin
         // Track enable writes; only bit 0 counts, unknown indexes are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            reg_index = csr_paddr[CSR_ADDR_W-1:2];
            case (reg_index)
               REG_USE_LOWER:    alphabet.use_lower    = csr_pwdata[0];
               REG_USE_UPPER:    alphabet.use_upper    = csr_pwdata[0];
               REG_USE_NUMERALS: alphabet.use_numerals = csr_pwdata[0];
               default: ;
            endcase
         end

         // Compare each result transaction with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed = '{char_code: rsp_mon.char_code, last_char: rsp_mon.last_char};
            if (expected_symbols.size() == 0) begin
               $error("unexpected symbol: char_code=%0d last_char=%0b",
                      observed.char_code, observed.last_char);
               error_tally++;
            end else begin
               predicted = expected_symbols.pop_front();
               if (observed.char_code !== predicted.char_code) begin
                  $error("char_code: expected %0d, got %0d",
                         predicted.char_code, observed.char_code);
                  error_tally++;
               end
               if (observed.last_char !== predicted.last_char) begin
                  $error("last_char: expected %0b, got %0b",
                         predicted.last_char, observed.last_char);
                  error_tally++;
               end
            end
         end

         // Predict the symbols of each accepted number
         if (req_mon.valid && req_mon.ready) begin
            predict_symbols(req_mon.number_in);
         end
      end
      symbol_errors   <= error_tally;
      symbols_pending <= expected_symbols.size();
   end

endmodule

>>> dv/testbench.sv
// Top of the radix alphabet encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import rae_pkg::*;

   // Slowest run: ~460 numbers x 19 digits with receiver stalls, several times over
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_COUNT = 48;
   localparam int PHASE_COUNT  = 9;

   // Address slot past the register list; writes there must be dropped
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    symbol_errors;
   int                    symbols_pending;
   int unsigned           cycle_count = 0;
   int unsigned           ready_hold;

   rae_req_if req_ch ();
   rae_rsp_if rsp_ch ();

   radix_alphabet_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   rae_symbol_checker symbol_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .symbol_errors   (symbol_errors),
      .symbols_pending (symbols_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[radix_alphabet_encoder_top] ERROR");
         $finish;
      end
   end

   // Receiver: hold ready at a random level for random stretches, some long
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 2) != 0);
         ready_hold   <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 4);
      end
   end

   // Numbers of random bit length; zero, all-ones and values below 64 each one time in 16
   function automatic logic [NUMBER_W-1:0] random_number();
      logic [63:0] raw;
      int unsigned span;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return NUMBER_W'($urandom_range(0, 63));
         default: begin
            span = $urandom_range(1, NUMBER_W);
            return NUMBER_W'(raw >> (64 - span));
         end
      endcase
   endfunction

   // APB write; leave the bus selected so back-to-back writes need no release
   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // Set one enable; upper data bits are random junk half the time
   function automatic logic [CSR_DATA_W-1:0] enable_word(input logic enable);
      logic [CSR_DATA_W-1:0] word;
      word    = ($urandom_range(0, 1) != 0) ? CSR_DATA_W'($urandom()) : '0;
      word[0] = enable;
      return word;
   endfunction

   task automatic set_alphabet(input cfg_type alphabet);
      write_register(REG_USE_LOWER, enable_word(alphabet.use_lower));
      write_register(REG_USE_UPPER, enable_word(alphabet.use_upper));
      write_register(REG_USE_NUMERALS, enable_word(alphabet.use_numerals));
      write_register(REG_UNUSED, CSR_DATA_W'($urandom()));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Send numbers in bursts of random length with random gaps between them
   task automatic send_numbers(input logic [NUMBER_W-1:0] numbers[$]);
      int unsigned burst_left;
      int unsigned gap;
      burst_left = 0;
      foreach (numbers[i]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_ch.valid     <= 1'b1;
         req_ch.number_in <= numbers[i];
         do @(posedge clock); while (!req_ch.ready);
         burst_left--;
      end
      req_ch.valid <= 1'b0;
   endtask

   initial begin
      cfg_type               phase_cfg[PHASE_COUNT];
      logic [NUMBER_W-1:0]   numbers[$];

      // Reset alphabet first, then the empty one, each single group, each pair, all again
      phase_cfg = '{3'b111, 3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b011, 3'b101, 3'b111};

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.number_in <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         set_alphabet(phase_cfg[phase]);
         numbers.delete();
         if (phase == 0) begin
            // Group boundaries in radix 62, the radix and one below its square, alternating bit patterns
            numbers = '{NUMBER_W'(0), NUMBER_W'(25), NUMBER_W'(26), NUMBER_W'(51),
                        NUMBER_W'(52), NUMBER_W'(61), NUMBER_W'(62), NUMBER_W'(3843),
                        {NUMBER_W{1'b1}}, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555};
         end else begin
            numbers = '{NUMBER_W'(0), {NUMBER_W{1'b1}}};
         end
         repeat (RANDOM_COUNT) numbers = {numbers, random_number()};
         send_numbers(numbers);

         // Drain all symbols before touching the enables again
         do @(posedge clock); while (symbols_pending != 0);
      end

      // Let any stray symbol show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (symbol_errors == 0 && symbols_pending == 0) begin
         $display("[radix_alphabet_encoder_top] OK");
      end else begin
         $display("[radix_alphabet_encoder_top] ERROR");
      end
      $finish;
   end

endmodule
